[src/assert_macros.svh]
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SPCB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

`define SPCB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`else

`define SPCB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SPCB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[src/spcb_pkg.sv]
package spcb_pkg;

    localparam int MAX_PAYLOAD = 6;
    localparam int PIDX_W      = $clog2(MAX_PAYLOAD);

    localparam int MAX_BEATS   = 6;
    localparam int BEAT_W      = $clog2(MAX_BEATS + 1);
    localparam int BIDX_W      = $clog2(MAX_BEATS);

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);
    localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] IN_SERIAL = 2'd0;
    localparam logic [1:0] IN_SPI    = 2'd1;
    localparam logic [1:0] IN_ADC    = 2'd2;

    localparam logic [1:0] OUT_SERIAL    = 2'd0;
    localparam logic [1:0] OUT_SPI       = 2'd1;
    localparam logic [1:0] OUT_RESET     = 2'd2;
    localparam logic [1:0] OUT_ADC_START = 2'd3;

    localparam logic [7:0] CMD_RESET = 8'd2;
    localparam logic [7:0] CMD_SPI   = 8'd3;
    localparam logic [7:0] CMD_ADC   = 8'd4;

    localparam logic [7:0] SPI_LEN    = 8'd4;
    localparam logic [7:0] ONE_LEN    = 8'd1;
    localparam logic [7:0] RESP_TAG   = 8'd3;
    localparam logic [7:0] RESP_LEN   = 8'd4;
    localparam logic [7:0] ADC_TAG    = 8'd4;
    localparam logic [7:0] ADC_LEN    = 8'd2;

    localparam int         LEFT_ADJ_BIT = 5;
    localparam logic [7:0] CHAN_RESET   = 8'h20;

    typedef enum logic [2:0] {
        PH_CMD  = 3'd0,
        PH_LEN  = 3'd1,
        PH_DATA = 3'd2,
        PH_SKIP = 3'd3,
        PH_SPI  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [1:0]                  okind;
        logic [BEAT_W-1:0]           nbeats;
        logic [MAX_BEATS-1:0][7:0]   bytes;
    } job_t;

endpackage

[src/spcb_in_if.sv]
interface spcb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [9:0] sample;

    modport source (output valid, kind, byte_value, sample, input ready);
    modport sink   (input valid, kind, byte_value, sample, output ready);
endinterface

[src/spcb_out_if.sv]
interface spcb_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, out_kind, out_byte, last, input ready);
    modport sink   (input valid, out_kind, out_byte, last, output ready);
endinterface

[src/spcb_front.sv]
module spcb_front (
    input  logic          clk,
    input  logic          rst_n,
    spcb_in_if.sink       item,
    input  logic          q_ready,
    output logic          job_valid,
    output spcb_pkg::job_t job
);
    import spcb_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] command_reg, command_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] chan_reg, chan_next;
    logic       armed_reg, armed_next;
    logic [7:0] pay_reg  [MAX_PAYLOAD];
    logic [7:0] pay_next [MAX_PAYLOAD];

    logic       accept;
    logic       run;
    logic [7:0] run_len;
    logic [7:0] count_inc;
    logic [7:0] adc_lo, adc_hi;

    assign item.ready = q_ready;
    assign accept     = item.valid && item.ready;
    assign count_inc  = 8'(count_reg + 8'd1);

    always_comb
    begin
        if (chan_reg[LEFT_ADJ_BIT])
        begin
            adc_hi = item.sample[9:2];
            adc_lo = {item.sample[1:0], 6'b0};
        end
        else
        begin
            adc_lo = item.sample[7:0];
            adc_hi = {6'b0, item.sample[9:8]};
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        command_next = command_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        chan_next    = chan_reg;
        armed_next   = armed_reg;
        pay_next     = pay_reg;
        run          = 1'b0;
        run_len      = length_reg;
        job_valid    = 1'b0;
        job          = '0;

        if (accept)
        begin
            case (item.kind)
                IN_SERIAL:
                begin
                    case (phase_reg)
                        PH_CMD:
                        begin
                            command_next = item.byte_value;
                            phase_next   = PH_LEN;
                        end
                        PH_LEN:
                        begin
                            length_next = item.byte_value;
                            run_len     = item.byte_value;
                            count_next  = '0;
                            if (item.byte_value > 8'(MAX_PAYLOAD))
                                phase_next = PH_SKIP;
                            else if (item.byte_value == 8'd0)
                                run = 1'b1;
                            else
                                phase_next = PH_DATA;
                        end
                        PH_DATA:
                        begin
                            if (count_reg < 8'(MAX_PAYLOAD))
                                pay_next[count_reg[PIDX_W-1:0]] = item.byte_value;
                            count_next = count_inc;
                            if (count_inc >= length_reg)
                                run = 1'b1;
                        end
                        PH_SKIP:
                        begin
                            count_next = count_inc;
                            if (count_inc >= length_reg)
                                phase_next = PH_CMD;
                        end
                        default:
                        begin
                        end
                    endcase

                    if (run)
                    begin
                        phase_next = PH_CMD;
                        case (command_reg)
                            CMD_RESET:
                            begin
                                if (run_len == ONE_LEN)
                                begin
                                    job_valid     = 1'b1;
                                    job.okind     = OUT_RESET;
                                    job.nbeats    = BEAT_W'(1);
                                    job.bytes[0]  = {7'b0, pay_next[0] != 8'd0};
                                end
                            end
                            CMD_SPI:
                            begin
                                if (run_len == SPI_LEN)
                                begin
                                    job_valid    = 1'b1;
                                    job.okind    = OUT_SPI;
                                    job.nbeats   = BEAT_W'(4);
                                    job.bytes[0] = pay_next[0];
                                    job.bytes[1] = pay_next[1];
                                    job.bytes[2] = pay_next[2];
                                    job.bytes[3] = pay_next[3];
                                    count_next   = '0;
                                    phase_next   = PH_SPI;
                                end
                            end
                            CMD_ADC:
                            begin
                                if (run_len == ONE_LEN)
                                    chan_next = pay_next[0] & ~CHAN_RESET;
                                armed_next   = 1'b1;
                                job_valid    = 1'b1;
                                job.okind    = OUT_ADC_START;
                                job.nbeats   = BEAT_W'(1);
                                job.bytes[0] = chan_next;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                IN_SPI:
                begin
                    if (phase_reg == PH_SPI)
                    begin
                        if (count_reg < 8'd4)
                            pay_next[count_reg[PIDX_W-1:0]] = item.byte_value;
                        count_next = count_inc;
                        if (count_inc >= 8'd4)
                        begin
                            phase_next   = PH_CMD;
                            job_valid    = 1'b1;
                            job.okind    = OUT_SERIAL;
                            job.nbeats   = BEAT_W'(6);
                            job.bytes[0] = RESP_TAG;
                            job.bytes[1] = RESP_LEN;
                            job.bytes[2] = pay_next[0];
                            job.bytes[3] = pay_next[1];
                            job.bytes[4] = pay_next[2];
                            job.bytes[5] = pay_next[3];
                        end
                    end
                end
                IN_ADC:
                begin
                    if (armed_reg)
                    begin
                        job_valid    = 1'b1;
                        job.okind    = OUT_SERIAL;
                        job.nbeats   = BEAT_W'(4);
                        job.bytes[0] = ADC_TAG;
                        job.bytes[1] = ADC_LEN;
                        job.bytes[2] = adc_lo;
                        job.bytes[3] = adc_hi;
                    end
                    armed_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_CMD;
            command_reg <= '0;
            length_reg  <= '0;
            count_reg   <= '0;
            chan_reg    <= CHAN_RESET;
            armed_reg   <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            chan_reg    <= chan_next;
            armed_reg   <= armed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pay_reg <= pay_next;
    end

endmodule

[src/spcb_queue.sv]
module spcb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  spcb_pkg::job_t push_job,
    output logic           ready,
    output logic           head_valid,
    output spcb_pkg::job_t head,
    input  logic           pop
);
    import spcb_pkg::*;

    job_t            mem_reg [QUEUE_DEPTH];
    logic [Q_AW-1:0] wr_reg, wr_next;
    logic [Q_AW-1:0] rd_reg, rd_next;
    logic [Q_CW-1:0] cnt_reg, cnt_next;
    logic            do_pop;

    assign ready      = cnt_reg != Q_CW'(QUEUE_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head       = mem_reg[rd_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : Q_AW'(wr_reg + 1'b1);
        if (do_pop)
            rd_next = (rd_reg == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : Q_AW'(rd_reg + 1'b1);
        if (push && !do_pop)
            cnt_next = Q_CW'(cnt_reg + 1'b1);
        else if (!push && do_pop)
            cnt_next = Q_CW'(cnt_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_job;
    end

endmodule

[src/spcb_back.sv]
`include "assert_macros.svh"

module spcb_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  spcb_pkg::job_t head,
    output logic           pop,
    spcb_out_if.source     result
);
    import spcb_pkg::*;

    logic [BIDX_W-1:0] idx_reg, idx_next;
    logic              last_beat;
    logic              beat;

    assign last_beat       = BEAT_W'(BEAT_W'(idx_reg) + 1'b1) == head.nbeats;
    assign beat            = result.valid && result.ready;
    assign pop             = beat && last_beat;

    assign result.valid    = head_valid;
    assign result.out_kind = head.okind;
    assign result.out_byte = head.bytes[idx_reg];
    assign result.last     = last_beat;

    always_comb
    begin
        idx_next = idx_reg;
        if (beat)
            idx_next = last_beat ? '0 : BIDX_W'(idx_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

    `SPCB_ASSERT_IMP(a_nbeats_nonzero, clk, rst_n, head_valid, head.nbeats != '0)
    `SPCB_ASSERT_IMP(a_idx_in_job, clk, rst_n, head_valid, BEAT_W'(idx_reg) < head.nbeats)
    `SPCB_ASSERT_NXT(a_idx_restart, clk, rst_n, pop, idx_reg == '0)

endmodule

[src/serial_packet_command_bridge.sv]
// Serial packet command bridge. Items on the item channel are serial bytes, SPI replies and
// conversion-done events; the front classifies each one in the cycle it is accepted, updates
// the packet deframer state and, when a packet runs or a reply or report completes, can push
// one job into a two-entry job queue. The back sequencer expands each job into 1 to 6 result
// beats, one per cycle while the result channel is ready. An item is accepted every cycle
// while the job queue has room, so items that cause no result stream at one per cycle; the
// sustained rate under output load is one result beat per cycle, set by the back sequencer;
// a 6-byte SPI answer holds its job until its last beat. There is no clearing pass after reset.
module serial_packet_command_bridge (
    input  logic       clk,
    input  logic       rst_n,
    spcb_in_if.sink    item,
    spcb_out_if.source result
);
    import spcb_pkg::*;

    logic q_ready;
    logic job_valid;
    job_t job;
    logic head_valid;
    job_t head;
    logic pop;

    spcb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .q_ready   (q_ready),
        .job_valid (job_valid),
        .job       (job)
    );

    spcb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_valid),
        .push_job   (job),
        .ready      (q_ready),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    spcb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .result     (result)
    );

endmodule
